### src/bit_parallel_nfa_byte_matcher_defines.svh
// Assertion macros for the NFA byte matcher.
// No dependencies; included by files that carry concurrent checks.
`ifndef BIT_PARALLEL_NFA_BYTE_MATCHER_DEFINES_SVH
`define BIT_PARALLEL_NFA_BYTE_MATCHER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BPNM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BPNM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/bpnm_pkg.sv
// Shared constants, types and helpers for the NFA byte matcher.
// No dependencies.
package bpnm_pkg;

    localparam int NUM_STATES      = 32;
    localparam int POSITION_BITS   = 16;
    localparam int STATE_IDX_BITS  = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
    localparam int WORD_BITS       = 32;
    localparam int END_BITS        = 16;
    localparam int CLASS_DEPTH     = 256;
    localparam int CLASS_ADDR_BITS = 8;
    localparam int WORD_COPY_BITS  = (NUM_STATES < WORD_BITS) ? NUM_STATES : WORD_BITS;
    localparam int END_COPY_BITS   = (POSITION_BITS < END_BITS) ? POSITION_BITS : END_BITS;

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    localparam logic [7:0] NUM_STATES_IDX = 8'(NUM_STATES);

    // command codes
    localparam logic [1:0] CMD_FOLLOW = 2'd0;
    localparam logic [1:0] CMD_CLASS  = 2'd1;
    localparam logic [1:0] CMD_BYTE   = 2'd2;
    localparam logic [1:0] CMD_END    = 2'd3;

    // register indexes
    localparam logic [1:0] CFG_START    = 2'd0;
    localparam logic [1:0] CFG_ACCEPT   = 2'd1;
    localparam logic [1:0] CFG_ANCHORED = 2'd2;

    typedef logic [NUM_STATES-1:0] state_set_t;

    typedef struct packed {
        logic       fire;   // stage-2 word leaves this cycle
        logic [1:0] cmd;
    } bpnm_step_t;

    typedef struct packed {
        logic                matched;
        logic [END_BITS-1:0] match_end;
    } bpnm_result_t;

    typedef struct packed {
        logic                 valid;
        logic [1:0]           index;
        logic [WORD_BITS-1:0] data;
    } bpnm_cfg_t;

    // drop bits at or above NUM_STATES, zero-fill if states outnumber word bits
    function automatic state_set_t word_to_states(input logic [WORD_BITS-1:0] w);
        state_set_t r;
        r = '0;
        for (int i = 0; i < WORD_COPY_BITS; i++) r[i] = w[i];
        return r;
    endfunction

    function automatic logic [END_BITS-1:0] pos_to_end(input logic [POSITION_BITS-1:0] p);
        logic [END_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < END_COPY_BITS; i++) r[i] = p[i];
        return r;
    endfunction

endpackage

### src/bpnm_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bpnm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### src/bpnm_follow.sv
// Follow-set register file and union of follow sets over the active set.
// Depends on bpnm_pkg.
module bpnm_follow (
    input  logic                   aclk,
    input  logic                   we,
    input  logic [7:0]             waddr,
    input  bpnm_pkg::state_set_t   wdata,
    input  bpnm_pkg::state_set_t   active,
    output bpnm_pkg::state_set_t   union_set
);
    import bpnm_pkg::*;

    state_set_t follow_reg [NUM_STATES];

    always_ff @(posedge aclk) begin
        if (we) begin
            follow_reg[waddr[STATE_IDX_BITS-1:0]] <= wdata;
        end
    end

    // each state gates its own entry; OR across states
    always_comb begin
        union_set = '0;
        for (int i = 0; i < NUM_STATES; i++) begin
            union_set = union_set | (follow_reg[i] & {NUM_STATES{active[i]}});
        end
    end
endmodule

### src/bpnm_core.sv
// Matcher state: config registers, active set, position, best end, flags.
// Depends on bpnm_pkg.
module bpnm_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  bpnm_pkg::bpnm_cfg_t    cfg,
    input  bpnm_pkg::bpnm_step_t   step,
    input  bpnm_pkg::state_set_t   union_set,
    input  bpnm_pkg::state_set_t   class_mask,
    output bpnm_pkg::state_set_t   active,
    output bpnm_pkg::bpnm_result_t result
);
    import bpnm_pkg::*;

    logic [WORD_BITS-1:0]     start_reg;
    logic [WORD_BITS-1:0]     accept_reg;
    logic                     anchored_reg;
    state_set_t               active_reg,   active_next;
    logic [POSITION_BITS-1:0] pos_reg,      pos_next;
    logic [POSITION_BITS-1:0] best_reg,     best_next;
    logic                     found_reg,    found_next;
    logic                     dead_reg,     dead_next;
    logic                     hit;

    assign hit = |(active_reg & word_to_states(accept_reg));

    always_comb begin
        active_next = active_reg;
        pos_next    = pos_reg;
        best_next   = best_reg;
        found_next  = found_reg;
        dead_next   = dead_reg;
        if (step.fire) begin
            case (step.cmd)
                CMD_BYTE: begin
                    if (!dead_reg) begin
                        if (!anchored_reg && hit) begin
                            best_next  = pos_reg;
                            found_next = 1'b1;
                        end
                        if (active_reg == '0) begin
                            dead_next = 1'b1;
                        end else begin
                            active_next = union_set & class_mask;
                            if (pos_reg != POS_MAX) pos_next = pos_reg + 1'b1;
                        end
                    end
                end
                CMD_END: begin
                    active_next = word_to_states(start_reg);
                    pos_next    = '0;
                    best_next   = '0;
                    found_next  = 1'b0;
                    dead_next   = 1'b0;
                end
                default: ;
            endcase
        end
        // start mask loads the set too while no byte has been taken
        if (cfg.valid && cfg.index == CFG_START && pos_reg == '0 && !dead_reg) begin
            active_next = word_to_states(cfg.data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg    <= WORD_BITS'(1);
            accept_reg   <= '0;
            anchored_reg <= 1'b0;
            active_reg   <= word_to_states(WORD_BITS'(1));
            pos_reg      <= '0;
            best_reg     <= '0;
            found_reg    <= 1'b0;
            dead_reg     <= 1'b0;
        end else begin
            if (cfg.valid) begin
                case (cfg.index)
                    CFG_START:    start_reg    <= cfg.data;
                    CFG_ACCEPT:   accept_reg   <= cfg.data;
                    CFG_ANCHORED: anchored_reg <= cfg.data[0];
                    default: ;
                endcase
            end
            active_reg <= active_next;
            pos_reg    <= pos_next;
            best_reg   <= best_next;
            found_reg  <= found_next;
            dead_reg   <= dead_next;
        end
    end

    always_comb begin
        if (hit) begin
            result.matched   = 1'b1;
            result.match_end = pos_to_end(pos_reg);
        end else if (!anchored_reg && found_reg) begin
            result.matched   = 1'b1;
            result.match_end = pos_to_end(best_reg);
        end else begin
            result.matched   = 1'b0;
            result.match_end = '0;
        end
    end

    assign active = active_reg;
endmodule

### src/bit_parallel_nfa_byte_matcher.sv
// Bit-parallel NFA byte matcher: input register, class-mask RAM, step logic, output register.
// Accepted words enter the step stage register; an end word leaving it loads its result
// into the output register, on m_tdata. Throughput: one word per cycle unless an end word
// stalls behind a held result, set by the active-set update fed by the registered mask read.
// Reset (aresetn low, synchronous) clears control, resets the start mask to state 0 and arms
// the active set with it; follow sets and class masks hold nothing defined until written.
module bit_parallel_nfa_byte_matcher (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // table_index[7:0], table_word[39:8], subject_byte[47:40]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // matched[0], match_end[16:1], zero pad[23:17]
    // config write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import bpnm_pkg::*;
    `include "bit_parallel_nfa_byte_matcher_defines.svh"

    logic [1:0]           in_cmd;
    logic [7:0]           in_index;
    logic [WORD_BITS-1:0] in_word;
    logic [7:0]           in_byte;
    logic                 s_accept;

    assign in_cmd   = s_tuser;
    assign in_index = s_tdata[7:0];
    assign in_word  = s_tdata[39:8];
    assign in_byte  = s_tdata[47:40];
    assign s_accept = s_tvalid && s_tready;

    // step stage register
    logic       s2_valid_reg;
    logic [1:0] s2_cmd_reg;
    logic       advance;
    logic       s2_fire;

    // result register
    logic                out_valid_reg;
    logic                out_matched_reg;
    logic [END_BITS-1:0] out_end_reg;

    // only an end word can stall, and only behind a held result
    assign advance  = !s2_valid_reg || (s2_cmd_reg != CMD_END) || !out_valid_reg || m_tready;
    assign s2_fire  = s2_valid_reg && advance;
    assign s_tready = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (advance) begin
            s2_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s2_cmd_reg <= in_cmd;
        end
    end

    // table writes land at accept, ahead of any later byte in the step stage
    logic follow_we;
    logic class_we;
    logic class_re;
    assign follow_we = s_accept && in_cmd == CMD_FOLLOW && in_index < NUM_STATES_IDX;
    assign class_we  = s_accept && in_cmd == CMD_CLASS;
    assign class_re  = s_accept && in_cmd == CMD_BYTE;

    state_set_t class_mask;
    state_set_t union_set;
    state_set_t active;

    bpnm_ram #(
        .WIDTH (NUM_STATES),
        .DEPTH (CLASS_DEPTH)
    ) u_class_ram (
        .aclk  (aclk),
        .we    (class_we),
        .waddr (in_index),
        .wdata (word_to_states(in_word)),
        .re    (class_re),
        .raddr (in_byte),
        .rdata (class_mask)
    );

    bpnm_follow u_follow (
        .aclk      (aclk),
        .we        (follow_we),
        .waddr     (in_index),
        .wdata     (word_to_states(in_word)),
        .active    (active),
        .union_set (union_set)
    );

    bpnm_cfg_t    cfg;
    bpnm_step_t   step;
    bpnm_result_t result;

    assign cfg_ready  = 1'b1;
    assign cfg.valid  = cfg_valid;
    assign cfg.index  = cfg_index;
    assign cfg.data   = cfg_data;
    assign step.fire  = s2_fire;
    assign step.cmd   = s2_cmd_reg;

    bpnm_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .step       (step),
        .union_set  (union_set),
        .class_mask (class_mask),
        .active     (active),
        .result     (result)
    );

    // result register: loads on a departing end word, frees on handoff
    logic end_fire;
    assign end_fire = s2_fire && s2_cmd_reg == CMD_END;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (end_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (end_fire) begin
            out_matched_reg <= result.matched;
            out_end_reg     <= result.match_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_end_reg, out_matched_reg};

    `BPNM_ASSERT_NEXT(a_end_gives_result, aclk, aresetn, end_fire, m_tvalid,
        "end word left the step stage without a result")
    `BPNM_ASSERT_SAME(a_stall_only_on_end, aclk, aresetn, !s_tready,
        s2_valid_reg && s2_cmd_reg == CMD_END && m_tvalid && !m_tready,
        "input stalled without a blocked end word")
    `BPNM_ASSERT_SAME(a_nomatch_zero_end, aclk, aresetn, m_tvalid && !m_tdata[0],
        m_tdata[16:1] == '0, "no-match result carries a nonzero end")
    `BPNM_ASSERT_NEXT(a_no_phantom_result, aclk, aresetn, !m_tvalid && !end_fire, !m_tvalid,
        "result appeared without an end word")
endmodule
